// File: rtl/core/fwq_pkg.sv
// Package for the futex wait-queue manager: sizes, op codes and beat types.
// Used by every module under rtl/core.
`default_nettype none
package fwq_pkg;
    localparam int NumSlots   = 64;
    localparam int QueueDepth = 16;
    localparam int IdW        = 6;
    localparam int HeadW      = 4;
    localparam int CntW       = 5;
    localparam int StoreAw    = IdW + HeadW;

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SIGNAL = 2'd2,
        OP_WAIT   = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]         op;
        logic [IdW-1:0]     slot_id;
        logic [15:0]        caller;
        logic signed [31:0] current_value;
        logic               read_ok;
        logic signed [31:0] expected_value;
    } t_req;

    typedef struct packed {
        logic [15:0]    target;
        logic           status;
        logic [IdW-1:0] new_id;
        logic           last;
    } t_msg;

    // Classified command handed from the front part to the back part.
    typedef struct packed {
        t_op            op;
        logic [IdW-1:0] slot_id;
        logic [15:0]    caller;
        logic           match;
        logic           read_ok;
    } t_cmd;
endpackage
`default_nettype wire

// File: rtl/core/fwq_front.sv
// Front part: accepts requests, compares values and pushes commands into a queue.
// Depends on fwq_pkg.
`default_nettype none
module fwq_front
    import fwq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_req i_data,
    output logic      o_cmd_valid,
    input  wire logic i_cmd_pop,
    output t_cmd      o_cmd
);
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;
    t_cmd       w_cmd;

    // Classification of one request.
    always_comb begin
        w_cmd.op       = t_op'(i_data.op);
        w_cmd.slot_id  = i_data.slot_id;
        w_cmd.caller   = i_data.caller;
        w_cmd.match    = (i_data.current_value == i_data.expected_value);
        w_cmd.read_ok  = i_data.read_ok;
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign w_push      = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    // Two-entry command queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cmd;
    end
endmodule
`default_nettype wire

// File: rtl/core/fwq_back.sv
// Back part: slot table, queue state memory, waiter memory and the message sequencer.
// Depends on fwq_pkg.
`default_nettype none
module fwq_back
    import fwq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    output logic      o_cmd_pop,
    input  wire t_cmd i_cmd,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_msg      o_data
);
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_READ   = 5'b00100,
        S_WAKE   = 5'b01000,
        S_LAST   = 5'b10000
    } t_state;

    // Per-slot queue state: number of waiters and ring index of the oldest.
    typedef struct packed {
        logic [CntW-1:0]  count;
        logic [HeadW-1:0] head;
    } t_qent;

    t_state              r_state, n_state;
    logic [NumSlots-1:0] r_used;
    logic [NumSlots-1:0] r_qvalid;
    t_qent               r_qmem [NumSlots];
    t_qent               r_qrd;
    logic                r_qrd_ok;
    logic [15:0]         r_mem  [NumSlots*QueueDepth];
    logic [15:0]         r_rdata;
    t_cmd                r_cmd;
    logic [CntW-1:0]     r_left, n_left;
    logic [HeadW-1:0]    r_ptr, n_ptr;
    logic                r_last_err, n_last_err;
    logic [IdW-1:0]      r_last_id, n_last_id;
    logic                r_ovalid;
    t_msg                r_odata;
    logic                w_free;
    logic [IdW-1:0]      w_free_id;
    logic                w_out_free;
    logic                w_emit;
    logic [CntW-1:0]     w_cnt;
    logic [HeadW-1:0]    w_hd;
    logic                w_enq;
    logic                w_qwe;
    t_qent               w_qwdata;
    logic [StoreAw-1:0]  w_raddr;
    logic [StoreAw-1:0]  w_waddr;

    // Lowest free slot by priority search.
    always_comb begin
        w_free    = 1'b0;
        w_free_id = '0;
        for (int k = NumSlots-1; k >= 0; k--) begin
            if (!r_used[k]) begin
                w_free = 1'b1; w_free_id = IdW'(k);
            end
        end
    end

    // A slot whose queue state was never written, or was cleared, reads as empty.
    assign w_cnt      = r_qrd_ok ? r_qrd.count : '0;
    assign w_hd       = r_qrd_ok ? r_qrd.head : '0;
    assign w_out_free = !r_ovalid || !i_stall;
    assign w_emit     = ((r_state == S_WAKE) || (r_state == S_LAST)) && w_out_free;
    assign o_cmd_pop  = (r_state == S_IDLE) && i_cmd_valid;
    assign o_valid    = r_ovalid;
    assign o_data     = r_odata;
    assign w_raddr    = {r_cmd.slot_id, r_ptr};
    assign w_waddr    = {r_cmd.slot_id, HeadW'(w_hd + w_cnt[HeadW-1:0])};
    assign w_enq      = (r_state == S_DECODE) && (r_cmd.op == OP_WAIT) && r_cmd.read_ok
                        && r_cmd.match && (w_cnt < CntW'(QueueDepth));
    assign w_qwe      = w_enq || ((r_state == S_DECODE) && (r_cmd.op == OP_SIGNAL)
                                  && (w_cnt != '0));

    // New queue state for a signal pop or a wait push.
    always_comb begin
        if (r_cmd.op == OP_SIGNAL) begin
            w_qwdata.count = w_cnt - 1'b1;
            w_qwdata.head  = w_hd + 1'b1;
        end else begin
            w_qwdata.count = w_cnt + 1'b1;
            w_qwdata.head  = w_hd;
        end
    end

    // Queue state memory: written in decode, read at the slot of the next command.
    always_ff @(posedge i_clk) begin
        if (w_qwe) r_qmem[r_cmd.slot_id] <= w_qwdata;
        r_qrd    <= r_qmem[i_cmd.slot_id];
        r_qrd_ok <= r_qvalid[i_cmd.slot_id];
    end

    // Waiter memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_enq) r_mem[w_waddr] <= r_cmd.caller;
        r_rdata <= r_mem[w_raddr];
    end

    // Sequencer next state.
    always_comb begin
        n_state    = r_state;
        n_left     = r_left;
        n_ptr      = r_ptr;
        n_last_err = r_last_err;
        n_last_id  = r_last_id;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                n_ptr      = w_hd;
                n_left     = w_cnt;
                n_last_err = 1'b0;
                n_last_id  = '0;
                n_state    = S_LAST;
                unique case (r_cmd.op)
                    OP_CREATE: begin
                        if (w_free) begin
                            n_last_id = w_free_id;
                        end else begin
                            n_last_err = 1'b1;
                        end
                    end
                    OP_REMOVE: begin
                        if (w_cnt != '0) n_state = S_READ;
                    end
                    OP_SIGNAL: begin
                        if (w_cnt != '0) begin
                            n_left  = CntW'(1);
                            n_state = S_READ;
                        end
                    end
                    OP_WAIT: begin
                        if (!r_cmd.read_ok) begin
                            n_last_err = 1'b1;
                        end else if (r_cmd.match) begin
                            if (w_cnt < CntW'(QueueDepth)) begin
                                n_state = S_IDLE;
                            end else begin
                                n_last_err = 1'b1;
                            end
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            // Memory read of the waiter at r_ptr lands in r_rdata.
            S_READ: n_state = S_WAKE;
            S_WAKE: begin
                if (w_out_free) begin
                    n_ptr   = r_ptr + 1'b1;
                    n_left  = r_left - 1'b1;
                    n_state = (r_left == CntW'(1)) ? S_LAST : S_READ;
                end
            end
            S_LAST: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer registers, slot table and queue state valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_used     <= '0;
            r_qvalid   <= '0;
            r_ovalid   <= 1'b0;
            r_left     <= '0;
            r_ptr      <= '0;
            r_last_err <= 1'b0;
            r_last_id  <= '0;
        end else begin
            r_state    <= n_state;
            r_left     <= n_left;
            r_ptr      <= n_ptr;
            r_last_err <= n_last_err;
            r_last_id  <= n_last_id;
            r_ovalid   <= w_emit || (r_ovalid && i_stall);
            if (r_state == S_DECODE) begin
                unique case (r_cmd.op)
                    OP_CREATE: begin
                        if (w_free) begin
                            r_used[w_free_id]   <= 1'b1;
                            r_qvalid[w_free_id] <= 1'b0;
                        end
                    end
                    OP_REMOVE: begin
                        r_used[r_cmd.slot_id]   <= 1'b0;
                        r_qvalid[r_cmd.slot_id] <= 1'b0;
                    end
                    OP_SIGNAL: begin
                        if (w_qwe) r_qvalid[r_cmd.slot_id] <= 1'b1;
                    end
                    OP_WAIT: begin
                        if (w_qwe) r_qvalid[r_cmd.slot_id] <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Command capture and output beat.
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) r_cmd <= i_cmd;
        if (w_emit) begin
            if (r_state == S_WAKE) begin
                r_odata <= '{target: r_rdata, status: (r_cmd.op == OP_REMOVE),
                             new_id: '0, last: 1'b0};
            end else begin
                r_odata <= '{target: r_cmd.caller, status: r_last_err,
                             new_id: r_last_id, last: 1'b1};
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/futex_wait_queue_manager.sv
// Futex wait-queue manager: a front part classifies requests into a two-entry
// command queue and a back part pops one command at a time, reads the slot's queue
// state from a registered memory, then walks the waiter memory. The reply beat to a
// create, a failed or mismatched wait, or a signal or remove on an empty queue is
// presented from the last state right after decode; a wait that puts its caller to
// sleep sends nothing. A signal with a waiter reads that waiter, presents its wake,
// then its reply. A remove reads and wakes each waiter in turn through the
// registered read port of the waiter memory, then presents its reply. A stalled
// beat holds the sequencer until it is taken. Depends on fwq_pkg.
`default_nettype none
module futex_wait_queue_manager
    import fwq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_req i_data,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_msg      o_data
);
    logic w_cmd_valid, w_cmd_pop;
    t_cmd w_cmd;

    fwq_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data,
        .o_cmd_valid(w_cmd_valid), .i_cmd_pop(w_cmd_pop), .o_cmd(w_cmd)
    );

    fwq_back u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(w_cmd_valid), .o_cmd_pop(w_cmd_pop),
        .i_cmd(w_cmd), .o_valid, .i_stall, .o_data
    );
endmodule
`default_nettype wire

// File: rtl/core/fwq_checker.sv
// Port-level checker for the futex wait-queue manager, bound to the top level.
// Depends on fwq_pkg.
`default_nettype none
module fwq_checker
    import fwq_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_valid,
    input wire logic i_stall,
    input wire t_msg o_data
);
    // A stalled beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data)) else $error("beat changed");
    // Wake beats carry no slot id.
    a_wake_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.last |-> o_data.new_id == '0) else $error("wake id");
    // An error reply never carries a slot id.
    a_err_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status && o_data.last |-> o_data.new_id == '0)
        else $error("error id");
endmodule

bind futex_wait_queue_manager fwq_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_data
);
`default_nettype wire
